### hw/rtl/xcft_pkg.sv
// Shared types and constants of the command frame transceiver.
`timescale 1ns / 1ps
`default_nettype none

package xcft_pkg;

  localparam int FRAME_LEN = 8;
  localparam int CNT_W     = $clog2(FRAME_LEN);
  localparam int REM_W     = $clog2(FRAME_LEN + 1);
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FUNC_SEND = 2'd0,
    FUNC_RX   = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_FAIL    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL = CFG_IDX_W'(1);

  // One run of results, handed from the engine to the output stage.
  typedef struct packed {
    logic                      is_reply;
    logic [FRAME_LEN-1:0][7:0] bytes;
    logic [1:0]                status;
    logic [7:0]                reply_hi;
    logic [7:0]                reply_lo;
    logic [7:0]                reply_code;
  } run_t;

endpackage

`default_nettype wire

### hw/rtl/xcft_in_if.sv
// Input item channel of the command frame transceiver.
`timescale 1ns / 1ps
`default_nettype none

interface xcft_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  cmd_code;
  logic [7:0]  param_one;
  logic [7:0]  param_two;
  logic [7:0]  param_three;
  logic [15:0] wait_limit;
  logic [7:0]  rx_byte;

  modport source (
    output valid, func, cmd_code, param_one, param_two, param_three, wait_limit, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, func, cmd_code, param_one, param_two, param_three, wait_limit, rx_byte,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/xcft_out_if.sv
// Result item channel of the command frame transceiver.
`timescale 1ns / 1ps
`default_nettype none

interface xcft_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic [1:0] status;
  logic [7:0] reply_hi;
  logic [7:0] reply_lo;
  logic [7:0] reply_code;
  logic       last;

  modport source (
    output valid, kind, tx_byte, status, reply_hi, reply_lo, reply_code, last,
    input  ready
  );
  modport sink (
    input  valid, kind, tx_byte, status, reply_hi, reply_lo, reply_code, last,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/xcft_cfg_if.sv
// Configuration write channel of the command frame transceiver.
`timescale 1ns / 1ps
`default_nettype none

interface xcft_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [xcft_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                     data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/xcft_engine.sv
// Input register, reply window state and per-item decision logic.
`timescale 1ns / 1ps
`default_nettype none

module xcft_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  xcft_in_if.sink          in_i,
  input  wire logic [7:0]  frame_head_i,
  input  wire logic [7:0]  frame_tail_i,
  input  wire logic        load_ok_i,
  output      logic        load_o,
  output      xcft_pkg::run_t run_o
);
  import xcft_pkg::*;

  logic        valid_q;
  logic [1:0]  func_q;
  logic [7:0]  cmd_q, p1_q, p2_q, p3_q, rx_q;
  logic [15:0] wait_q;

  logic             armed_q, armed_d;
  logic [CNT_W-1:0] rx_count_q, rx_count_d;
  logic [7:0]       expected_q, expected_d;
  logic [15:0]      elapsed_q, elapsed_d;
  logic [15:0]      limit_q, limit_d;
  logic [FRAME_LEN-1:0][7:0] rx_frame_q;

  logic        has_result;
  logic        wr_en;
  logic        go;
  logic [15:0] elapsed_inc;
  logic [7:0]  chk;
  logic        bad;
  run_t        run;

  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign chk = rx_frame_q[1] ^ rx_frame_q[2] ^ rx_frame_q[3] ^ rx_frame_q[4] ^ rx_frame_q[5];
  // The eighth byte is the one in hand; the first seven are already stored.
  assign bad = (rx_frame_q[0] != frame_head_i) || (rx_q != frame_tail_i) ||
               (rx_frame_q[1] != expected_q) || (chk != rx_frame_q[6]);

  always_comb begin
    armed_d    = armed_q;
    rx_count_d = rx_count_q;
    expected_d = expected_q;
    elapsed_d  = elapsed_q;
    limit_d    = limit_q;
    has_result = 1'b0;
    wr_en      = 1'b0;
    run        = '0;
    case (func_q)
      FUNC_SEND: begin
        has_result   = 1'b1;
        run.is_reply = KIND_TX;
        run.bytes[0] = frame_head_i;
        run.bytes[1] = cmd_q;
        run.bytes[2] = p1_q;
        run.bytes[3] = p2_q;
        run.bytes[4] = p3_q;
        run.bytes[5] = 8'h00;
        run.bytes[6] = cmd_q ^ p1_q ^ p2_q ^ p3_q;
        run.bytes[FRAME_LEN-1] = frame_tail_i;
        armed_d    = 1'b1;
        rx_count_d = '0;
        expected_d = cmd_q;
        elapsed_d  = '0;
        limit_d    = wait_q;
      end
      FUNC_RX: begin
        if (armed_q && (elapsed_q < limit_q) &&
            !((rx_count_q == '0) && (rx_q != frame_head_i))) begin
          if (rx_count_q == CNT_W'(FRAME_LEN - 1)) begin
            has_result     = 1'b1;
            run.is_reply   = KIND_REPLY;
            run.status     = bad ? ST_FAIL : ST_SUCCESS;
            run.reply_hi   = rx_frame_q[2];
            run.reply_lo   = rx_frame_q[3];
            run.reply_code = rx_frame_q[4];
            armed_d        = 1'b0;
            rx_count_d     = '0;
          end else begin
            wr_en      = 1'b1;
            rx_count_d = rx_count_q + CNT_W'(1);
          end
        end
      end
      FUNC_TICK: begin
        if (armed_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= limit_q) begin
            has_result   = 1'b1;
            run.is_reply = KIND_REPLY;
            run.status   = ST_TIMEOUT;
            armed_d      = 1'b0;
            rx_count_d   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // An item with no result never waits for the output stage.
  assign go         = valid_q && (!has_result || load_ok_i);
  assign load_o     = go && has_result;
  assign run_o      = run;
  assign in_i.ready = !valid_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      armed_q    <= 1'b0;
      rx_count_q <= '0;
      expected_q <= '0;
      elapsed_q  <= '0;
      limit_q    <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        valid_q <= 1'b1;
      end else if (go) begin
        valid_q <= 1'b0;
      end
      if (go) begin
        armed_q    <= armed_d;
        rx_count_q <= rx_count_d;
        expected_q <= expected_d;
        elapsed_q  <= elapsed_d;
        limit_q    <= limit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q <= in_i.func;
      cmd_q  <= in_i.cmd_code;
      p1_q   <= in_i.param_one;
      p2_q   <= in_i.param_two;
      p3_q   <= in_i.param_three;
      wait_q <= in_i.wait_limit;
      rx_q   <= in_i.rx_byte;
    end
    if (go && wr_en) begin
      rx_frame_q[rx_count_q] <= rx_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/xcft_out_run.sv
// Result register that plays out a run of results, one per ready cycle.
`timescale 1ns / 1ps
`default_nettype none

module xcft_out_run (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire xcft_pkg::run_t run_i,
  output      logic load_ok_o,
  xcft_out_if.source out_o
);
  import xcft_pkg::*;

  logic [REM_W-1:0]          remain_q;
  logic                      is_reply_q;
  logic [FRAME_LEN-1:0][7:0] bytes_q;
  logic [1:0]                status_q;
  logic [7:0]                hi_q, lo_q, code_q;
  logic                      pop;

  assign pop       = out_o.valid && out_o.ready;
  assign load_ok_o = (remain_q == '0) || (pop && (remain_q == REM_W'(1)));

  assign out_o.valid      = (remain_q != '0);
  assign out_o.kind       = is_reply_q;
  assign out_o.tx_byte    = bytes_q[0];
  assign out_o.status     = status_q;
  assign out_o.reply_hi   = hi_q;
  assign out_o.reply_lo   = lo_q;
  assign out_o.reply_code = code_q;
  assign out_o.last       = (remain_q == REM_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else if (load_i) begin
      remain_q <= run_i.is_reply ? REM_W'(1) : REM_W'(FRAME_LEN);
    end else if (pop) begin
      remain_q <= remain_q - REM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      is_reply_q <= run_i.is_reply;
      bytes_q    <= run_i.bytes;
      status_q   <= run_i.status;
      hi_q       <= run_i.reply_hi;
      lo_q       <= run_i.reply_lo;
      code_q     <= run_i.reply_code;
    end else if (pop) begin
      bytes_q <= {8'h00, bytes_q[FRAME_LEN-1:1]};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/xor_command_frame_transceiver_core.sv
// Top level of the eight-byte XOR checksum command frame transceiver.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Role    Carries
// -------  ------  -------------------------------------------------------
// in_i     sink    func, cmd_code, params, wait_limit, rx_byte per item
// out_o    source  kind, tx_byte, status, reply bytes, last per item
// cfg_i    sink    index and data of a frame_head or frame_tail write
//
// Every input item passes an input register and is decided while held there,
// so one item per cycle is accepted when its results can enter the result
// register. A send makes a run of eight transmit items, drained at one per cycle
// while out_o is ready; receive bytes and ticks that give no result never wait
// on the output register. Reset clears the window state and restores both frame
// byte registers to 0xF5. A stalled output holds its item while the input
// register keeps accepting until it holds an item with results.
module xor_command_frame_transceiver_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  xcft_in_if.sink    in_i,
  xcft_out_if.source out_o,
  xcft_cfg_if.sink   cfg_i
);
  import xcft_pkg::*;

  logic [7:0] frame_head_q;
  logic [7:0] frame_tail_q;
  logic       load;
  logic       load_ok;
  run_t       run;

  // The register file is always ready; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_head_q <= 8'hF5;
      frame_tail_q <= 8'hF5;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_HEAD: frame_head_q <= cfg_i.data;
        CFG_TAIL: frame_tail_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  xcft_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .frame_head_i (frame_head_q),
    .frame_tail_i (frame_tail_q),
    .load_ok_i    (load_ok),
    .load_o       (load),
    .run_o        (run)
  );

  xcft_out_run u_out_run (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .run_i     (run),
    .load_ok_o (load_ok),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

### tb/xcft_frame_check.sv
// Result checker of the command frame transceiver: predicts and compares result items.
`timescale 1ns / 1ps

module xcft_frame_check (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  xcft_in_if          in_mon,
  xcft_out_if         out_mon,
  xcft_cfg_if         cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import xcft_pkg::*;

  localparam logic [7:0]  FRAME_BYTE_RESET = 8'hF5;
  localparam logic [15:0] MS_SATURATED     = 16'hFFFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    status_e    status;
    logic [7:0] reply_hi;
    logic [7:0] reply_lo;
    logic [7:0] reply_code;
    logic       last;
  } frame_result_t;

  // Copy of the register file and of the reply window.
  logic [7:0]    head_q;
  logic [7:0]    tail_q;
  logic          window_armed;
  int            rx_fill;
  logic [7:0]    rx_bytes [FRAME_LEN];
  logic [7:0]    echo_cmd;
  logic [15:0]   ms_elapsed;
  logic [15:0]   ms_limit;

  frame_result_t awaited_q [$];
  frame_result_t oldest;
  int unsigned   mismatches;

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void close_window(status_e st, logic [7:0] hi, logic [7:0] lo,
                                       logic [7:0] code);
    frame_result_t r;
    r            = '0;
    r.kind       = KIND_REPLY;
    r.status     = st;
    r.reply_hi   = hi;
    r.reply_lo   = lo;
    r.reply_code = code;
    r.last       = 1'b1;
    awaited_q.push_back(r);
    window_armed = 1'b0;
    rx_fill      = 0;
  endfunction

  // Advances the window state by one accepted input item and queues what it yields.
  function automatic void advance_transceiver(logic [1:0] f, logic [7:0] cmd, logic [7:0] p1,
                                              logic [7:0] p2, logic [7:0] p3,
                                              logic [15:0] wl, logic [7:0] b);
    logic [7:0]    fr [FRAME_LEN];
    logic [7:0]    sum;
    frame_result_t r;
    case (f)
      FUNC_SEND: begin
        fr[0] = head_q;
        fr[1] = cmd;
        fr[2] = p1;
        fr[3] = p2;
        fr[4] = p3;
        fr[5] = 8'h00;
        fr[6] = fr[1] ^ fr[2] ^ fr[3] ^ fr[4] ^ fr[5];
        fr[7] = tail_q;
        for (int i = 0; i < FRAME_LEN; i++) begin
          r         = '0;
          r.kind    = KIND_TX;
          r.tx_byte = fr[i];
          r.status  = ST_SUCCESS;
          r.last    = (i == FRAME_LEN - 1);
          awaited_q.push_back(r);
        end
        window_armed = 1'b1;
        rx_fill      = 0;
        echo_cmd     = cmd;
        ms_elapsed   = '0;
        ms_limit     = wl;
      end
      FUNC_RX: begin
        if (window_armed && ms_elapsed < ms_limit && !(rx_fill == 0 && b != head_q)) begin
          if (rx_fill >= FRAME_LEN) rx_fill = 0;
          rx_bytes[rx_fill] = b;
          rx_fill++;
          if (rx_fill == FRAME_LEN) begin
            sum = rx_bytes[1] ^ rx_bytes[2] ^ rx_bytes[3] ^ rx_bytes[4] ^ rx_bytes[5];
            if (rx_bytes[0] != head_q || rx_bytes[7] != tail_q ||
                rx_bytes[1] != echo_cmd || sum != rx_bytes[6]) begin
              close_window(ST_FAIL, rx_bytes[2], rx_bytes[3], rx_bytes[4]);
            end else begin
              close_window(ST_SUCCESS, rx_bytes[2], rx_bytes[3], rx_bytes[4]);
            end
          end
        end
      end
      FUNC_TICK: begin
        if (window_armed) begin
          if (ms_elapsed != MS_SATURATED) ms_elapsed++;
          if (ms_elapsed >= ms_limit) close_window(ST_TIMEOUT, 8'h00, 8'h00, 8'h00);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       = FRAME_BYTE_RESET;
      tail_q       = FRAME_BYTE_RESET;
      window_armed = 1'b0;
      rx_fill      = 0;
      echo_cmd     = '0;
      ms_elapsed   = '0;
      ms_limit     = '0;
      mismatches   = 0;
      awaited_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_q.size() == 0) begin
          $error("result item with nothing expected: kind %0d, tx_byte 0x%0h",
                 out_mon.kind, out_mon.tx_byte);
          mismatches++;
        end else begin
          oldest = awaited_q.pop_front();
          check_field("kind", oldest.kind, out_mon.kind);
          check_field("tx_byte", oldest.tx_byte, out_mon.tx_byte);
          check_field("status", oldest.status, out_mon.status);
          check_field("reply_hi", oldest.reply_hi, out_mon.reply_hi);
          check_field("reply_lo", oldest.reply_lo, out_mon.reply_lo);
          check_field("reply_code", oldest.reply_code, out_mon.reply_code);
          check_field("last", oldest.last, out_mon.last);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_HEAD: head_q = cfg_mon.data;
          CFG_TAIL: tail_q = cfg_mon.data;
          default: begin
          end
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        advance_transceiver(in_mon.func, in_mon.cmd_code, in_mon.param_one, in_mon.param_two,
                            in_mon.param_three, in_mon.wait_limit, in_mon.rx_byte);
      end
      fail_count_o <= mismatches;
      pending_o    <= awaited_q.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the transceiver testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 1ps

module testbench;
  import xcft_pkg::*;

  // Index that the register file ignores, and the func code that the block ignores.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  localparam logic [1:0]           FUNC_SPARE = 2'd3;

  localparam logic [7:0] FRAME_BYTE_RESET = 8'hF5;
  localparam int         SETTLE_CYCLES    = 4;
  localparam int         PHASE_ITEMS      = 64;

  // Ways to spoil a reply frame so that the block must report a failure.
  localparam int FLAW_NONE = 0;
  localparam int FLAW_TAIL = 1;
  localparam int FLAW_ECHO = 2;
  localparam int FLAW_SUM  = 3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  xcft_in_if  in_ch ();
  xcft_out_if out_ch ();
  xcft_cfg_if cfg_ch ();

  xor_command_frame_transceiver_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  int unsigned fail_count;
  int unsigned open_count;

  xcft_frame_check frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (open_count)
  );

  // The result sink runs in modes that change at random intervals: always
  // ready, a rotating stall pattern, or a coin toss per cycle. The pattern is
  // never all zero, so in that mode every stall ends within one turn of the pattern.
  logic       drain_ready = 1'b0;
  int         drain_mode  = 0;
  int         mode_left   = 0;
  logic [7:0] stall_pat   = 8'hFF;

  assign out_ch.ready = drain_ready;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      drain_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(16, 64);
      stall_pat  = 8'($urandom_range(1, 255));
    end else begin
      mode_left--;
    end
    case (drain_mode)
      0: drain_ready <= 1'b1;
      1: begin
        drain_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      default: drain_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Stimulus state. The current frame bytes are tracked only to shape the
  // reply frames so that most of them get past the head search.
  logic [7:0] cur_head   = FRAME_BYTE_RESET;
  logic [7:0] cur_tail   = FRAME_BYTE_RESET;
  int         items_sent = 0;
  int         burst_left = 0;
  bit         steady     = 1'b0;
  bit         carry      = 1'b0;
  logic [7:0] carry_cmd  = '0;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] non_head();
    logic [7:0] v;
    do v = rand_byte(); while (v == cur_head);
    return v;
  endfunction

  // Offers one item and returns once it is taken and any pause after it is over.
  // Between bursts the sender may pause; valid is only lowered when a pause really
  // follows, so a back-to-back item never sees valid dropped and raised in one step.
  task automatic offer(input logic [1:0] f, input logic [7:0] cmd, input logic [7:0] p1,
                       input logic [7:0] p2, input logic [7:0] p3,
                       input logic [15:0] wl, input logic [7:0] b);
    int pause;
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.cmd_code    <= cmd;
    in_ch.param_one   <= p1;
    in_ch.param_two   <= p2;
    in_ch.param_three <= p3;
    in_ch.wait_limit  <= wl;
    in_ch.rx_byte     <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (pause > 0) begin
          in_ch.valid <= 1'b0;
          repeat (pause) @(posedge clk);
        end
      end
    end
  endtask

  // Fields that an item kind does not use get random values, so their bits
  // toggle without meaning anything to the block.
  task automatic send_cmd(input logic [7:0] cmd, input logic [7:0] p1, input logic [7:0] p2,
                          input logic [7:0] p3, input logic [15:0] wl);
    offer(FUNC_SEND, cmd, p1, p2, p3, wl, rand_byte());
  endtask

  task automatic rx(input logic [7:0] b);
    offer(FUNC_RX, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 16'($urandom), b);
  endtask

  task automatic tick();
    offer(FUNC_TICK, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 16'($urandom),
          rand_byte());
  endtask

  // Feeds one eight-byte reply frame built from the current head and tail.
  // A flaw flips bits of the tail, the echoed command or the checksum; the
  // echo flaw is folded into the checksum so that only the echo is wrong.
  // With ticks enabled, a tick may fall before any byte, which now and then
  // runs the window out in the middle of the frame.
  task automatic reply_frame(input logic [7:0] cmd, input logic [7:0] hi, input logic [7:0] lo,
                             input logic [7:0] code, input logic [7:0] pad, input int flaw,
                             input bit with_ticks);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] flip;
    flip  = 8'($urandom_range(1, 255));
    fb[0] = cur_head;
    fb[1] = (flaw == FLAW_ECHO) ? cmd ^ flip : cmd;
    fb[2] = hi;
    fb[3] = lo;
    fb[4] = code;
    fb[5] = pad;
    fb[6] = fb[1] ^ fb[2] ^ fb[3] ^ fb[4] ^ fb[5];
    if (flaw == FLAW_SUM) fb[6] = fb[6] ^ flip;
    fb[7] = (flaw == FLAW_TAIL) ? cur_tail ^ flip : cur_tail;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (with_ticks && $urandom_range(0, 5) == 0) tick();
      rx(fb[i]);
    end
  endtask

  // One command exchange: a send, then usually a reply with some line noise
  // in front of it, sometimes ticks that reach the timeout when the wait is short,
  // and sometimes nothing, so the next send lands on a window still armed.
  task automatic exchange();
    logic [7:0]  cmd;
    logic [15:0] wl;
    int          flaw;
    int          n;
    cmd = rand_byte();
    case ($urandom_range(0, 9))
      0:       wl = '0;
      1:       wl = 16'($urandom);
      2:       wl = 16'hFFFF;
      default: wl = 16'($urandom_range(2, 12));
    endcase
    send_cmd(cmd, rand_byte(), rand_byte(), rand_byte(), wl);
    case ($urandom_range(0, 7))
      0: begin
        n = (wl <= 16) ? int'(wl) + 1 : $urandom_range(1, 4);
        repeat (n) tick();
      end
      1: begin
      end
      default: begin
        repeat ($urandom_range(0, 3)) rx(non_head());
        flaw = $urandom_range(0, 5);
        if (flaw > FLAW_SUM) flaw = FLAW_NONE;
        reply_frame(cmd, rand_byte(), rand_byte(), rand_byte(), rand_byte(), flaw, 1'b1);
        // A stray byte after the outcome finds the window closed.
        if ($urandom_range(0, 3) == 0) rx(rand_byte());
      end
    endcase
    // Occasional noise between exchanges, mostly while no window is open.
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0:       tick();
          1:       rx(rand_byte());
          default: offer(FUNC_SPARE, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                         16'($urandom), rand_byte());
        endcase
      end
    end
  endtask

  // Stops offering and waits until every expected result has come out, then
  // lets any item still in the input register that yields nothing pass through.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register. Valid drops for a cycle after each write so that a
  // following write never lowers and raises it within one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_HEAD) cur_head = value;
    if (idx == CFG_TAIL) cur_tail = value;
    @(posedge clk);
  endtask

  // One configuration phase. The window left open by the previous phase is
  // answered under the new frame bytes, since checks use the registers as they
  // stand when the reply arrives. Each phase ends with such an open window.
  task automatic run_phase(input logic [7:0] head, input logic [7:0] tail);
    int goal;
    write_reg(CFG_HEAD, head);
    write_reg(CFG_TAIL, tail);
    write_reg(CFG_SPARE, rand_byte());
    if (carry) begin
      reply_frame(carry_cmd, rand_byte(), rand_byte(), rand_byte(), rand_byte(), FLAW_NONE,
                  1'b0);
      carry = 1'b0;
    end
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) exchange();
    carry_cmd = rand_byte();
    send_cmd(carry_cmd, rand_byte(), rand_byte(), rand_byte(), 16'hFFFF);
    carry = 1'b1;
    settle();
  endtask

  initial begin
    logic [7:0] same;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_TICK;
    in_ch.cmd_code    = '0;
    in_ch.param_one   = '0;
    in_ch.param_two   = '0;
    in_ch.param_three = '0;
    in_ch.wait_limit  = '0;
    in_ch.rx_byte     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_HEAD;
    cfg_ch.data       = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the frame bytes at their reset value.
    // A tick, a byte and the unused func code while no window is open.
    tick();
    rx(FRAME_BYTE_RESET);
    offer(FUNC_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    // All-ones command and parameters with the longest wait, answered by a
    // clean reply: the outcome is a success.
    send_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    reply_frame(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, FLAW_NONE, 1'b0);
    // A zero wait takes no byte, not even a head, and the first tick times out.
    send_cmd(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
    rx(FRAME_BYTE_RESET);
    tick();
    // A send on an armed window abandons it; the new window times out.
    send_cmd(8'h5A, 8'hA5, 8'h3C, 8'hC3, 16'd2);
    send_cmd(8'h81, 8'h7E, 8'h01, 8'h80, 16'd2);
    tick();
    tick();
    settle();

    // Random part over several register settings, the extremes among them.
    same = rand_byte();
    run_phase(8'h00, 8'hFF);
    run_phase(8'hFF, 8'h00);
    run_phase(rand_byte(), rand_byte());
    run_phase(same, same);
    run_phase(FRAME_BYTE_RESET, FRAME_BYTE_RESET);

    // Window of eight ticks: a head byte one tick before the limit is still
    // taken, and the last tick reports the timeout with the frame only begun.
    steady = 1'b1;
    send_cmd(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 16'd8);
    repeat (7) tick();
    rx(cur_head);
    tick();
    steady = 1'b0;
    settle();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog that ends a run that hangs.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
